>>> design/rlhs_pkg.sv
// rlhs_pkg: shared types and constants of the rgb/luma histogram block
// word layouts, operation codes, register indexes, luma arithmetic constants
// depends on nothing
package rlhs_pkg;

   localparam int NUM_BINS   = 256;
   localparam int BIN_W      = 8;
   localparam int FIELD_W    = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_STATS = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AUTO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUDGET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RGBA   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MASK   = 3'd7;

   // rec.709 weights scaled by 10000, divide by 10000 via reciprocal
   localparam int LUMA_R     = 2126;
   localparam int LUMA_G     = 7152;
   localparam int LUMA_B     = 722;
   localparam int LUMA_BIAS  = 5000;
   localparam longint LUMA_RECIP = 64'd13743896;
   localparam int LUMA_SHIFT = 37;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] pixel_word;
      logic [7:0]  mask_value;
      logic [11:0] column;
      logic [11:0] row;
      logic [1:0]  channel;
      logic [7:0]  bin_index;
   } req_type;

   typedef struct packed {
      logic        sampled;
      logic [24:0] bin_count;
      logic [24:0] total_count;
      logic [15:0] mean_q8;
      logic [7:0]  median_level;
      logic [14:0] stddev_q8;
      logic [1:0]  level_used;
      logic        empty_res;
   } rsp_type;

endpackage

>>> design/rgb_luma_histogram_stats.sv
// rgb_luma_histogram_stats: red, green, blue and luma histograms with stats
// depends on rlhs_pkg, rlhs_mul and rlhs_div
//
// usage:
//  - a command word is taken at a clock edge with start high and busy low;
//    busy stays high until the command's result word has been sent
//  - every command gives one result word on rsp, marked by rsp_valid for
//    one cycle; the receiver cannot hold it off
//  - pixel: level/luma prep, grid check and luma divide, bin read, then
//    read-modify-write of all four banks if the pixel is sampled
//  - read bin: prep, bin read, result; clear: one bin address per cycle
//  - stats: two 256-bin sweeps of the bank (total/sum/sum of squares,
//    then median), three serial multiplies of COUNT_BITS+16 steps each,
//    two serial divides of 2*COUNT_BITS+48 steps each and a 15-step
//    square root; an empty channel ends after the first sweep
//  - one command at a time; the next may start in the cycle rsp_valid is high
//  - reset runs a clearing pass over all 256 bins with busy high;
//    it sends no result word; csr writes must only happen while idle
module rgb_luma_histogram_stats #(
   parameter int COUNT_BITS = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rlhs_pkg::req_type                  req,
   output logic                               rsp_valid,
   output rlhs_pkg::rsp_type                  rsp,
   input  logic                               csr_we,
   input  logic [rlhs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rlhs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rlhs_pkg::*;

   localparam int TOT_W = COUNT_BITS + 8;
   localparam int SUM_W = COUNT_BITS + 16;
   localparam int SQ_W  = COUNT_BITS + 24;
   localparam int VAR_W = 2 * COUNT_BITS + 32;
   localparam int NUM_W = VAR_W + 16;
   localparam int DEN_W = 2 * TOT_W;
   localparam int P_W   = SQ_W + SUM_W;
   localparam int WIDE_W = 48;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd1;
   localparam logic [3:0] ST_PIX1 = 4'd2;
   localparam logic [3:0] ST_PIX2 = 4'd3;
   localparam logic [3:0] ST_PIX3 = 4'd4;
   localparam logic [3:0] ST_RD1  = 4'd5;
   localparam logic [3:0] ST_RD2  = 4'd6;
   localparam logic [3:0] ST_CLR  = 4'd7;
   localparam logic [3:0] ST_SUM  = 4'd8;
   localparam logic [3:0] ST_MED  = 4'd9;
   localparam logic [3:0] ST_MTS  = 4'd10;
   localparam logic [3:0] ST_MSS  = 4'd11;
   localparam logic [3:0] ST_MTT  = 4'd12;
   localparam logic [3:0] ST_DVM  = 4'd13;
   localparam logic [3:0] ST_DVV  = 4'd14;
   localparam logic [3:0] ST_SQRT = 4'd15;

   // configuration registers
   logic [12:0] cfg_width_ff, cfg_height_ff;
   logic [1:0]  cfg_level_ff;
   logic        cfg_auto_ff, cfg_skip_ff, cfg_rgba_ff, cfg_mask_ff;
   logic [24:0] cfg_budget_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 13'd4096;
         cfg_height_ff <= 13'd4096;
         cfg_level_ff  <= '0;
         cfg_auto_ff   <= 1'b0;
         cfg_budget_ff <= '0;
         cfg_skip_ff   <= 1'b0;
         cfg_rgba_ff   <= 1'b0;
         cfg_mask_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH:  cfg_width_ff  <= csr_wdata[12:0];
            REG_HEIGHT: cfg_height_ff <= csr_wdata[12:0];
            REG_LEVEL:  cfg_level_ff  <= csr_wdata[1:0];
            REG_AUTO:   cfg_auto_ff   <= csr_wdata[0];
            REG_BUDGET: cfg_budget_ff <= csr_wdata;
            REG_SKIP:   cfg_skip_ff   <= csr_wdata[0];
            REG_RGBA:   cfg_rgba_ff   <= csr_wdata[0];
            REG_MASK:   cfg_mask_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   logic [3:0]             state_ff, state_in;
   logic [8:0]             cnt_ff, cnt_in;
   logic                   rdv_ff, rdv_in;
   logic [7:0]             idx_d_ff, idx_d_in;
   logic [15:0]            sq_ff, sq_in, sqd_ff, sqd_in;
   logic                   emit_clr_ff, emit_clr_in;
   logic                   launch_ff, launch_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   req_type                req_ff, req_in;
   logic [1:0]             level_ff, level_in;
   logic [7:0]             r_ff, r_in, g_ff, g_in, b_ff, b_in, a_ff, a_in;
   logic [21:0]            lsum_ff, lsum_in;
   logic [7:0]             luma_ff, luma_in;
   logic                   samp_ff, samp_in;
   logic [TOT_W-1:0]       total_ff, total_in, acc_ff, acc_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sumsq_ff, sumsq_in;
   logic                   found_ff, found_in;
   logic [7:0]             med_ff, med_in;
   logic [VAR_W-1:0]       var_ff, var_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [15:0]            mean_ff, mean_in;
   logic [29:0]            quo_ff, quo_in;
   logic [14:0]            k_ff, k_in, bit_ff, bit_in;

   // histogram banks: red, green, blue, luma
   logic [3:0][7:0]            mem_raddr, mem_waddr, pix_addr;
   logic [3:0][COUNT_BITS-1:0] mem_wdata, rdq_ff;
   logic [3:0]                 mem_we;

   for (genvar ch = 0; ch < 4; ch++) begin : g_bank
      logic [COUNT_BITS-1:0] bins_mem [NUM_BINS];
      always_ff @(posedge clock) begin
         if (mem_we[ch]) begin
            bins_mem[mem_waddr[ch]] <= mem_wdata[ch];
         end
         rdq_ff[ch] <= bins_mem[mem_raddr[ch]];
      end
   end

   assign pix_addr = {luma_ff, b_ff, g_ff, r_ff};

   always_comb begin
      mem_raddr = {4{cnt_ff[7:0]}};
      mem_waddr = pix_addr;
      mem_we    = '0;
      for (int ch = 0; ch < 4; ch++) begin
         // saturating bump of the read-back count
         mem_wdata[ch] = (rdq_ff[ch] == {COUNT_BITS{1'b1}}) ? rdq_ff[ch]
                         : rdq_ff[ch] + COUNT_BITS'(1);
      end
      case (state_ff)
         ST_PIX2: mem_raddr = pix_addr;
         ST_PIX3: mem_we    = {4{samp_ff}};
         ST_RD1:  mem_raddr = {4{req_ff.bin_index}};
         ST_CLR: begin
            mem_we    = 4'b1111;
            mem_waddr = {4{cnt_ff[7:0]}};
            mem_wdata = '0;
         end
         default: ;
      endcase
   end

   // shared serial arithmetic units
   logic               mul_start, mul_done, div_start, div_done;
   logic [SQ_W-1:0]    mul_a;
   logic [SUM_W-1:0]   mul_b;
   logic [P_W-1:0]     mul_prod;
   logic [NUM_W-1:0]   div_num, div_quot;
   logic [DEN_W-1:0]   div_den;

   assign mul_start = launch_ff &&
                      (state_ff == ST_MTS || state_ff == ST_MSS || state_ff == ST_MTT);
   assign div_start = launch_ff && (state_ff == ST_DVM || state_ff == ST_DVV);

   always_comb begin
      case (state_ff)
         ST_MTS: begin
            mul_a = sumsq_ff;
            mul_b = SUM_W'(total_ff);
         end
         ST_MSS: begin
            mul_a = SQ_W'(sum_ff);
            mul_b = sum_ff;
         end
         default: begin
            mul_a = SQ_W'(total_ff);
            mul_b = SUM_W'(total_ff);
         end
      endcase
      if (state_ff == ST_DVM) begin
         // mean: (sum * 512 + total) / (2 * total)
         div_num = NUM_W'({sum_ff, 9'b0}) + NUM_W'(total_ff);
         div_den = DEN_W'({total_ff, 1'b0});
      end else begin
         // 65536 * variance * total^2 over total^2
         div_num = {var_ff, 16'b0};
         div_den = den_ff;
      end
   end

   rlhs_mul #(.A_W(SQ_W), .B_W(SUM_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   rlhs_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // effective sampling level from size against budget
   logic [25:0] area;
   logic [29:0] area_x, budget_x;
   logic [1:0]  auto_level;

   assign area     = {13'b0, cfg_width_ff} * {13'b0, cfg_height_ff};
   assign area_x   = {4'b0, area};
   assign budget_x = {5'b0, cfg_budget_ff};

   always_comb begin
      if (area_x <= budget_x) begin
         auto_level = 2'd0;
      end else if (area_x <= {budget_x[27:0], 2'b0}) begin
         auto_level = 2'd1;
      end else if (area_x <= {budget_x[25:0], 4'b0}) begin
         auto_level = 2'd2;
      end else begin
         auto_level = 2'd3;
      end
   end

   // helper values
   logic [COUNT_BITS-1:0]    rdq_sel;
   logic [COUNT_BITS+7:0]    wsum_term;
   logic [COUNT_BITS+15:0]   wsq_term;
   logic [TOT_W-1:0]         acc_next;
   logic [TOT_W:0]           half;
   logic [45:0]              luma_prod;
   logic [2:0]               smask;
   logic [14:0]              cand;
   logic [29:0]              cand_sq;
   logic [WIDE_W-1:0]        bin_wide, tot_wide;
   logic [24:0]              bin_sat, tot_sat;

   assign rdq_sel   = rdq_ff[req_ff.channel];
   assign wsum_term = {{COUNT_BITS{1'b0}}, idx_d_ff} * {8'b0, rdq_sel};
   assign wsq_term  = {{COUNT_BITS{1'b0}}, sqd_ff} * {16'b0, rdq_sel};
   assign acc_next  = acc_ff + TOT_W'(rdq_sel);
   assign half      = ({1'b0, total_ff} + (TOT_W+1)'(1)) >> 1;
   assign luma_prod = {24'b0, lsum_ff} * 46'(LUMA_RECIP);
   assign smask     = 3'((4'd1 << level_ff) - 4'd1);
   assign cand      = k_ff | bit_ff;
   assign cand_sq   = {15'b0, cand} * {15'b0, cand};
   assign bin_wide  = WIDE_W'(rdq_sel);
   assign tot_wide  = WIDE_W'(total_ff);
   assign bin_sat   = (bin_wide > WIDE_W'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : bin_wide[24:0];
   assign tot_sat   = (tot_wide > WIDE_W'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : tot_wide[24:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rdv_in       = 1'b0;
      idx_d_in     = idx_d_ff;
      sq_in        = sq_ff;
      sqd_in       = sqd_ff;
      emit_clr_in  = emit_clr_ff;
      launch_in    = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      req_in       = req_ff;
      level_in     = level_ff;
      r_in         = r_ff;
      g_in         = g_ff;
      b_in         = b_ff;
      a_in         = a_ff;
      lsum_in      = lsum_ff;
      luma_in      = luma_ff;
      samp_in      = samp_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      found_in     = found_ff;
      med_in       = med_ff;
      var_in       = var_ff;
      den_in       = den_ff;
      mean_in      = mean_ff;
      quo_in       = quo_ff;
      k_in         = k_ff;
      bit_in       = bit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (cfg_level_ff != 2'd0 || !cfg_auto_ff || cfg_budget_ff == '0) begin
               level_in = cfg_level_ff;
            end else begin
               level_in = auto_level;
            end
            g_in = req_ff.pixel_word[15:8];
            a_in = req_ff.pixel_word[31:24];
            if (cfg_rgba_ff) begin
               r_in = req_ff.pixel_word[7:0];
               b_in = req_ff.pixel_word[23:16];
            end else begin
               b_in = req_ff.pixel_word[7:0];
               r_in = req_ff.pixel_word[23:16];
            end
            lsum_in = {14'b0, r_in} * 22'(LUMA_R) + {14'b0, g_in} * 22'(LUMA_G)
                    + {14'b0, b_in} * 22'(LUMA_B) + 22'(LUMA_BIAS);
            cnt_in   = '0;
            sq_in    = '0;
            total_in = '0;
            sum_in   = '0;
            sumsq_in = '0;
            case (req_ff.operation)
               OP_PIXEL: state_in = ST_PIX1;
               OP_READ:  state_in = ST_RD1;
               OP_STATS: state_in = ST_SUM;
               OP_CLEAR: begin
                  emit_clr_in = 1'b1;
                  state_in    = ST_CLR;
               end
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_PIX1: begin
            // grid, image bounds, mask and alpha checks; luma divide
            samp_in = ({1'b0, req_ff.column} < cfg_width_ff)
                   && ({1'b0, req_ff.row} < cfg_height_ff)
                   && ((req_ff.column[2:0] & smask) == 3'd0)
                   && ((req_ff.row[2:0] & smask) == 3'd0)
                   && !(cfg_mask_ff && req_ff.mask_value == 8'd0)
                   && !(cfg_skip_ff && a_ff == 8'd0);
            luma_in  = luma_prod[LUMA_SHIFT+7:LUMA_SHIFT];
            state_in = ST_PIX2;
         end
         ST_PIX2: state_in = ST_PIX3;
         ST_PIX3: begin
            rsp_in            = '0;
            rsp_in.level_used = level_ff;
            rsp_in.sampled    = samp_ff;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_RD1: state_in = ST_RD2;
         ST_RD2: begin
            rsp_in            = '0;
            rsp_in.level_used = level_ff;
            rsp_in.bin_count  = bin_sat;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_CLR: begin
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff[7:0] == 8'hff) begin
               cnt_in = '0;
               if (emit_clr_ff) begin
                  rsp_in            = '0;
                  rsp_in.level_used = level_ff;
                  rsp_valid_in      = 1'b1;
               end
               emit_clr_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         ST_SUM: begin
            // sweep: issue one bin address a cycle, accumulate its registered read-back count
            if (!cnt_ff[8]) begin
               cnt_in   = cnt_ff + 9'd1;
               rdv_in   = 1'b1;
               idx_d_in = cnt_ff[7:0];
               sqd_in   = sq_ff;
               sq_in    = sq_ff + {7'b0, cnt_ff[7:0], 1'b1};
            end
            if (rdv_ff) begin
               total_in = total_ff + TOT_W'(rdq_sel);
               sum_in   = sum_ff + SUM_W'(wsum_term);
               sumsq_in = sumsq_ff + SQ_W'(wsq_term);
            end
            if (cnt_ff[8] && !rdv_ff) begin
               cnt_in   = '0;
               acc_in   = '0;
               found_in = 1'b0;
               med_in   = '0;
               if (total_ff == '0) begin
                  rsp_in            = '0;
                  rsp_in.level_used = level_ff;
                  rsp_in.empty_res  = 1'b1;
                  rsp_valid_in      = 1'b1;
                  state_in          = ST_IDLE;
               end else begin
                  state_in = ST_MED;
               end
            end
         end
         ST_MED: begin
            // median: first bin whose running count reaches half
            if (!cnt_ff[8]) begin
               cnt_in   = cnt_ff + 9'd1;
               rdv_in   = 1'b1;
               idx_d_in = cnt_ff[7:0];
            end
            if (rdv_ff) begin
               acc_in = acc_next;
               if (!found_ff && {1'b0, acc_next} >= half) begin
                  found_in = 1'b1;
                  med_in   = idx_d_ff;
               end
            end
            if (cnt_ff[8] && !rdv_ff) begin
               launch_in = 1'b1;
               state_in  = ST_MTS;
            end
         end
         ST_MTS: begin
            if (mul_done) begin
               var_in    = mul_prod[VAR_W-1:0];
               launch_in = 1'b1;
               state_in  = ST_MSS;
            end
         end
         ST_MSS: begin
            if (mul_done) begin
               var_in    = var_ff - mul_prod[VAR_W-1:0];
               launch_in = 1'b1;
               state_in  = ST_MTT;
            end
         end
         ST_MTT: begin
            if (mul_done) begin
               den_in    = mul_prod[DEN_W-1:0];
               launch_in = 1'b1;
               state_in  = ST_DVM;
            end
         end
         ST_DVM: begin
            if (div_done) begin
               mean_in   = div_quot[15:0];
               launch_in = 1'b1;
               state_in  = ST_DVV;
            end
         end
         ST_DVV: begin
            if (div_done) begin
               quo_in   = div_quot[29:0];
               k_in     = '0;
               bit_in   = 15'h4000;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // floor square root of the quotient, one bit a cycle
            if (cand_sq <= quo_ff) begin
               k_in = cand;
            end
            bit_in = {1'b0, bit_ff[14:1]};
            if (bit_ff[0]) begin
               rsp_in              = '0;
               rsp_in.level_used   = level_ff;
               rsp_in.total_count  = tot_sat;
               rsp_in.mean_q8      = mean_ff;
               rsp_in.median_level = med_ff;
               rsp_in.stddev_q8    = (cand_sq <= quo_ff) ? cand : k_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         rdv_ff       <= 1'b0;
         emit_clr_ff  <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rdv_ff       <= rdv_in;
         emit_clr_ff  <= emit_clr_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         found_ff     <= found_in;
      end
      idx_d_ff <= idx_d_in;
      sq_ff    <= sq_in;
      sqd_ff   <= sqd_in;
      rsp_ff   <= rsp_in;
      req_ff   <= req_in;
      r_ff     <= r_in;
      g_ff     <= g_in;
      b_ff     <= b_in;
      a_ff     <= a_in;
      lsum_ff  <= lsum_in;
      luma_ff  <= luma_in;
      samp_ff  <= samp_in;
      total_ff <= total_in;
      acc_ff   <= acc_in;
      sum_ff   <= sum_in;
      sumsq_ff <= sumsq_in;
      med_ff   <= med_in;
      var_ff   <= var_in;
      den_ff   <= den_in;
      mean_ff  <= mean_in;
      quo_ff   <= quo_in;
      k_ff     <= k_in;
      bit_ff   <= bit_in;
   end

   assign busy      = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE && $past(state_ff) != ST_IDLE))
      else $error("result word sent outside end of a command");

   a_unit_start: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("multiplier and divider launched together");
`endif
endmodule

>>> design/rlhs_mul.sv
// rlhs_mul: shift-add multiplier, one multiplier bit per cycle
// used by the statistics sequencer; depends on nothing
module rlhs_mul #(
   parameter int A_W = 8,
   parameter int B_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] prod
);
   localparam int P_W = A_W + B_W;
   localparam int C_W = $clog2(B_W + 1);

   logic [P_W-1:0] acc_ff, acc_in, a_ff, a_in;
   logic [B_W-1:0] b_ff, b_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           run_ff, run_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         a_in   = {{B_W{1'b0}}, a};
         b_in   = b;
         cnt_in = C_W'(B_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[P_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[B_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

>>> design/rlhs_div.sv
// rlhs_div: restoring divider, one quotient bit per cycle
// used by the statistics sequencer; depends on nothing
module rlhs_div #(
   parameter int N_W = 16,
   parameter int D_W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic           done,
   output logic [N_W-1:0] quot
);
   localparam int C_W = $clog2(N_W + 1);

   logic [D_W:0]   rem_ff, rem_in, rem_sh;
   logic [N_W-1:0] num_ff, num_in;
   logic [D_W-1:0] den_ff, den_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           run_ff, run_in, done_ff, done_in, ge;

   // numerator shifts out at the top while quotient bits shift in below
   assign rem_sh = {rem_ff[D_W-1:0], num_ff[N_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         num_in = num;
         den_in = den;
         cnt_in = C_W'(N_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         num_in = {num_ff[N_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
endmodule

>>> test/tb.sv
// tb: self-checking bench for rgb_luma_histogram_stats
// predicts histogram bins, bin reads and channel stats, checks every result word
// depends on rlhs_pkg and the rgb_luma_histogram_stats rtl
`timescale 1ns / 100ps

module tb;
   import rlhs_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req = '0;
   logic        rsp_valid;
   rsp_type     rsp;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rgb_luma_histogram_stats uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp(rsp), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor copy of the block's registers and bins
   logic [12:0] img_w, img_h;
   logic [1:0]  lvl_req;
   logic        auto_on, skip_alpha, rgba_order, mask_on;
   logic [24:0] budget;
   longint unsigned hist [4][256];

   req_type cmd_queue [$];
   rsp_type expected_words [$];
   int      errors = 0;
   int      n_pixels = 0, n_sampled = 0, n_reads = 0, n_stats = 0, n_clears = 0;
   bit      driver_quiet = 1'b0;   // no idling near the end of the run
   int      gap_left = 0;
   int      idle_cycles = 0;

   function automatic logic [1:0] level_now();
      longint unsigned p, b;
      p = img_w * img_h;
      b = budget;
      if (lvl_req != 0 || !auto_on || b == 0) return lvl_req;
      if (p <= b) return 2'd0;
      if (p <= 4 * b) return 2'd1;
      if (p <= 16 * b) return 2'd2;
      return 2'd3;
   endfunction

   function automatic longint unsigned bump_bin(longint unsigned c);
      return (c >= 64'h1FFFFFF) ? 64'h1FFFFFF : c + 1;
   endfunction

   function automatic logic [24:0] clip25(longint unsigned v);
      return (v > 64'h1FFFFFF) ? 25'h1FFFFFF : v[24:0];
   endfunction

   // work out the result word of one command and update the bins
   function automatic rsp_type predict_word(req_type c);
      rsp_type w;
      logic [1:0] lv;
      logic [11:0] gmask;
      int unsigned r, g, b, a, y;
      longint unsigned total, sum, sumsq, acc, half, k, cand;
      logic [127:0] var16, kt2;
      w = '0;
      lv = level_now();
      w.level_used = lv;
      case (c.operation)
         OP_PIXEL: begin
            n_pixels++;
            gmask = (12'd1 << lv) - 12'd1;
            g = c.pixel_word[15:8];
            a = c.pixel_word[31:24];
            r = rgba_order ? c.pixel_word[7:0] : c.pixel_word[23:16];
            b = rgba_order ? c.pixel_word[23:16] : c.pixel_word[7:0];
            if (c.column < img_w && c.row < img_h && (c.column & gmask) == 0
                && (c.row & gmask) == 0 && !(mask_on && c.mask_value == 0)
                && !(skip_alpha && a == 0)) begin
               y = (2126 * r + 7152 * g + 722 * b + 5000) / 10000;
               hist[0][r] = bump_bin(hist[0][r]);
               hist[1][g] = bump_bin(hist[1][g]);
               hist[2][b] = bump_bin(hist[2][b]);
               hist[3][y] = bump_bin(hist[3][y]);
               w.sampled = 1'b1;
               n_sampled++;
            end
         end
         OP_READ: begin
            n_reads++;
            w.bin_count = clip25(hist[c.channel][c.bin_index]);
         end
         OP_STATS: begin
            n_stats++;
            total = 0; sum = 0; sumsq = 0;
            for (int i = 0; i < 256; i++) begin
               total += hist[c.channel][i];
               sum += i * hist[c.channel][i];
               sumsq += i * i * hist[c.channel][i];
            end
            if (total == 0) begin
               w.empty_res = 1'b1;
            end else begin
               w.total_count = clip25(total);
               w.mean_q8 = (sum * 512 + total) / (2 * total);
               half = (total + 1) / 2;
               acc = 0;
               for (int i = 0; i < 256; i++) begin
                  acc += hist[c.channel][i];
                  if (acc >= half) begin
                     w.median_level = i;
                     break;
                  end
               end
               var16 = ((128'(total) * 128'(sumsq)) - (128'(sum) * 128'(sum))) << 16;
               k = 0;
               for (int bt = 14; bt >= 0; bt--) begin
                  cand = k | (64'd1 << bt);
                  kt2 = 128'(cand * total) * 128'(cand * total);
                  if (kt2 <= var16) k = cand;
               end
               w.stddev_q8 = k[14:0];
            end
         end
         default: begin
            n_clears++;
            foreach (hist[ch, i]) hist[ch][i] = 0;
         end
      endcase
      return w;
   endfunction

   // driver: one command word at a time, random idle bursts between words
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_words.push_back(predict_word(req));
            if (!driver_quiet && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 19);
         end
         if (start && busy) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (cmd_queue.size() > 0 && !(start && !busy && cmd_queue.size() == 0)) begin
            req <= cmd_queue.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp);
               errors++;
            end else begin
               e = expected_words.pop_front();
               if (rsp.sampled !== e.sampled)
                  $display("%0t: sampled exp %h got %h", $time, e.sampled, rsp.sampled);
               if (rsp.bin_count !== e.bin_count)
                  $display("%0t: bin_count exp %0d got %0d", $time, e.bin_count, rsp.bin_count);
               if (rsp.total_count !== e.total_count)
                  $display("%0t: total_count exp %0d got %0d", $time, e.total_count,
                           rsp.total_count);
               if (rsp.mean_q8 !== e.mean_q8)
                  $display("%0t: mean_q8 exp %h got %h", $time, e.mean_q8, rsp.mean_q8);
               if (rsp.median_level !== e.median_level)
                  $display("%0t: median exp %0d got %0d", $time, e.median_level,
                           rsp.median_level);
               if (rsp.stddev_q8 !== e.stddev_q8)
                  $display("%0t: stddev_q8 exp %h got %h", $time, e.stddev_q8, rsp.stddev_q8);
               if (rsp.level_used !== e.level_used)
                  $display("%0t: level_used exp %0d got %0d", $time, e.level_used,
                           rsp.level_used);
               if (rsp.empty_res !== e.empty_res)
                  $display("%0t: empty_res exp %h got %h", $time, e.empty_res, rsp.empty_res);
               if (rsp !== e) errors++;
            end
         end
      end
   end

   // watchdog: cycles with no word accepted either way; covers reset clear and stats
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [24:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_WIDTH:  img_w = val[12:0];
         REG_HEIGHT: img_h = val[12:0];
         REG_LEVEL:  lvl_req = val[1:0];
         REG_AUTO:   auto_on = val[0];
         REG_BUDGET: budget = val;
         REG_SKIP:   skip_alpha = val[0];
         REG_RGBA:   rgba_order = val[0];
         default:    mask_on = val[0];
      endcase
   endtask

   // wait until every queued word is taken and every result is back
   task automatic drain();
      do @(posedge clock);
      while (cmd_queue.size() > 0 || start || busy || expected_words.size() > 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic push_cmd(input logic [1:0] op, input logic [31:0] px, input logic [7:0] mk,
                           input logic [11:0] col, input logic [11:0] rw,
                           input logic [1:0] ch, input logic [7:0] bi);
      req_type c;
      c.operation = op; c.pixel_word = px; c.mask_value = mk;
      c.column = col; c.row = rw; c.channel = ch; c.bin_index = bi;
      cmd_queue.push_back(c);
   endtask

   // mostly on-image pixels with small coordinates, some full-range noise
   task automatic random_cmds(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            push_cmd(OP_PIXEL, $urandom, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                     ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)),
                     ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40)),
                     2'($urandom), 8'($urandom));
         else if (pick < 88)
            push_cmd(OP_READ, $urandom, 8'($urandom), 12'($urandom), 12'($urandom),
                     2'($urandom), 8'($urandom));
         else if (pick < 98)
            push_cmd(OP_STATS, $urandom, 8'($urandom), 12'($urandom), 12'($urandom),
                     2'($urandom), 8'($urandom));
         else
            push_cmd(OP_CLEAR, $urandom, 8'($urandom), 12'($urandom), 12'($urandom),
                     2'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      img_w = 13'd4096; img_h = 13'd4096; lvl_req = 0; auto_on = 0; budget = 0;
      skip_alpha = 0; rgba_order = 0; mask_on = 0;
      foreach (hist[ch, i]) hist[ch][i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      drain();

      // directed: extremes of fields, every operation, stats of an empty channel
      push_cmd(OP_STATS, 0, 0, 0, 0, 2'd3, 0);
      push_cmd(OP_PIXEL, 32'hFFFFFFFF, 8'hFF, 0, 0, 0, 0);
      push_cmd(OP_PIXEL, 32'h00000000, 8'h00, 12'd4095, 12'd4095, 2'd3, 8'hFF);
      push_cmd(OP_PIXEL, 32'h00FF0000, 8'h01, 12'd1, 12'd1, 0, 0);
      push_cmd(OP_PIXEL, 32'h000000FF, 8'h80, 12'd2, 12'd2, 0, 0);
      push_cmd(OP_PIXEL, 32'h0000FF00, 8'h7F, 12'hAAA, 12'h555, 0, 0);
      push_cmd(OP_READ, 0, 0, 0, 0, 2'd0, 8'hFF);
      push_cmd(OP_READ, 0, 0, 0, 0, 2'd3, 8'h00);
      for (int ch = 0; ch < 4; ch++) push_cmd(OP_STATS, 0, 0, 0, 0, 2'(ch), 0);
      push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      push_cmd(OP_READ, 0, 0, 0, 0, 2'd0, 8'hFF);
      push_cmd(OP_STATS, 0, 0, 0, 0, 2'd1, 0);
      drain();

      // masked, alpha-skipped, rgba order, small image with fixed level
      write_reg(REG_WIDTH, 25'd37); write_reg(REG_HEIGHT, 25'd29);
      write_reg(REG_LEVEL, 25'd1); write_reg(REG_SKIP, 25'd1);
      write_reg(REG_RGBA, 25'd1); write_reg(REG_MASK, 25'd1);
      push_cmd(OP_PIXEL, 32'h00123456, 8'h10, 0, 0, 0, 0);
      push_cmd(OP_PIXEL, 32'h01123456, 8'h00, 0, 0, 0, 0);
      push_cmd(OP_PIXEL, 32'h80ABCDEF, 8'h01, 12'd36, 12'd28, 0, 0);
      push_cmd(OP_PIXEL, 32'h80ABCDEF, 8'h01, 12'd37, 12'd2, 0, 0);
      push_cmd(OP_PIXEL, 32'h80ABCDEF, 8'h01, 12'd3, 12'd2, 0, 0);
      random_cmds(100);
      drain();

      // automatic level choice from budget, at the equal and four-times ends
      write_reg(REG_LEVEL, 25'd0); write_reg(REG_AUTO, 25'd1);
      write_reg(REG_BUDGET, 25'd1); write_reg(REG_SKIP, 25'd0);
      write_reg(REG_RGBA, 25'd0);
      random_cmds(60);
      drain();
      write_reg(REG_WIDTH, 25'd4096); write_reg(REG_HEIGHT, 25'd4096);
      write_reg(REG_BUDGET, 25'h1000000);
      random_cmds(60);
      drain();
      write_reg(REG_BUDGET, 25'h0400000); write_reg(REG_MASK, 25'd0);
      random_cmds(60);
      drain();
      write_reg(REG_BUDGET, 25'h1FFFFFF); write_reg(REG_LEVEL, 25'd3);
      write_reg(REG_WIDTH, 25'd1); write_reg(REG_HEIGHT, 25'd1);
      random_cmds(40);
      drain();
      write_reg(REG_WIDTH, 25'd64); write_reg(REG_HEIGHT, 25'd64);
      write_reg(REG_LEVEL, 25'd2); write_reg(REG_AUTO, 25'd0);
      random_cmds(60);
      drain();

      // last part without idling
      write_reg(REG_LEVEL, 25'd0);
      driver_quiet = 1'b1;
      random_cmds(60);
      drain();

      $display("tb: %0d pixels (%0d binned), %0d bin reads, %0d stats, %0d clears",
               n_pixels, n_sampled, n_reads, n_stats, n_clears);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
design/rlhs_pkg.sv
design/rlhs_mul.sv
design/rlhs_div.sv
design/rgb_luma_histogram_stats.sv
test/tb.sv
